// ===== src/ovn2d_pkg.sv =====
// ---------------------------------------------------------------------------
// ovn2d_pkg
// Shared types and constants of the octave value noise unit: field widths,
// fixed-point formats, state enums and the divider request/response structs.
// ---------------------------------------------------------------------------
package ovn2d_pkg;

  // field widths
  localparam int SEED_W   = 16;
  localparam int COORD_W  = 7;
  localparam int OCT_W    = 3;
  localparam int BIAS_W   = 14;

  // octave weight, unsigned Q16.24 saturated to 40 bits
  localparam int WGT_W    = 40;
  localparam int WGT_HALF = 20;
  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(64'd1 << 24);
  localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};

  // accumulators: up to seven octaves of value times weight
  localparam int ACC_W    = 59;
  localparam int WSUM_W   = 43;

  // shared divider
  localparam int DIV_W    = 64;
  localparam int QUO_W    = 40;
  localparam int QB_W     = 6;
  localparam logic [QB_W-1:0] WGT_QBITS = QB_W'(40);
  localparam logic [QB_W-1:0] OUT_QBITS = QB_W'(16);

  localparam logic [SEED_W-1:0] OUT_MAX = {SEED_W{1'b1}};

  // input item kinds carried on tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // register indexes on the configuration port
  localparam logic REG_OCTAVE_COUNT = 1'b0;
  localparam logic REG_SCALING_BIAS = 1'b1;

  // reset values of the configuration registers
  localparam logic [OCT_W-1:0]  OCT_RESET  = OCT_W'(5);
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(512);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIVW,
    ST_DIVF,
    ST_OUT
  } nv_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_t;

  // divide num by dsh >> (qbits - 1): dsh is the divisor
  // already aligned to the top quotient bit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] dsh;
    logic [QB_W-1:0]  qbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== src/octave_value_noise_2d_unit.sv =====
// ---------------------------------------------------------------------------
// octave_value_noise_2d_unit
// Octave value noise over a SIDE x SIDE seed map. A beat with tuser = 0 writes
// one seed word at (x_pos, y_pos). A beat with tuser = 1 sums N octaves
// (octave_count, zero taken as one, capped at log2(SIDE)): each octave reads
// four corner seeds from the seed RAM, blends them and weights the blend on
// one shared multiplier that takes the weight in 20-bit halves, then divides
// 256 times the weight by scaling_bias on the shared one-bit-per-cycle divider
// (stopping early when the weight saturates; skipped after the last octave).
// A final divide normalizes the weighted sum by the sum of the weights. No
// input is taken while a query runs. A finished result sits in an output
// register, so loads and the next query are taken while it waits. Seeds must
// be written before any query reads them.
// ---------------------------------------------------------------------------
module octave_value_noise_2d_unit #(
  parameter int SIDE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_pos[6:0], y_pos[13:7], seed_value[29:14], zero
  input  logic [0:0]  in_tuser,   // func[0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // noise_value[15:0]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import ovn2d_pkg::*;

  localparam int LG      = $clog2(SIDE);
  localparam int PW      = LG + 1;
  localparam int AW      = 2 * LG;
  localparam int TOP_W   = SEED_W + LG;
  localparam int BL_W    = SEED_W + 2 * LG;
  localparam int P_W     = TOP_W + WGT_HALF;
  localparam int PLOG_W  = $clog2(LG + 1);
  localparam int SH_W    = PLOG_W + 1;
  localparam int OCT_CAP = (LG > 7) ? 7 : LG;

  // sequencer steps
  localparam logic [3:0] RS_LAST    = 4'd4;
  localparam logic [3:0] MS_TOP_A   = 4'd0;
  localparam logic [3:0] MS_TOP_B   = 4'd1;
  localparam logic [3:0] MS_BOT_A   = 4'd2;
  localparam logic [3:0] MS_BOT_B   = 4'd3;
  localparam logic [3:0] MS_BLEND_A = 4'd4;
  localparam logic [3:0] MS_BLEND_B = 4'd5;
  localparam logic [3:0] MS_SHIFT   = 4'd6;
  localparam logic [3:0] MS_ACC_LO  = 4'd7;
  localparam logic [3:0] MS_ACC_HI  = 4'd8;
  localparam logic [3:0] DS_START   = 4'd0;
  localparam logic [3:0] DS_WAIT    = 4'd1;

  nv_state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  // configuration registers
  logic [OCT_W-1:0]  octave_count_r;
  logic [BIAS_W-1:0] scaling_bias_r;
  logic              cfg_wr;

  // query context
  logic [LG-1:0]     x_r, y_r;
  logic [OCT_W-1:0]  octs_r, oct_r;
  logic [BIAS_W-1:0] bias_r;
  logic [WGT_W-1:0]  weight_r;
  logic [ACC_W-1:0]  acc_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [SEED_W-1:0] seed_r [4];
  logic [TOP_W-1:0]  top_r, bot_r;
  logic [BL_W-1:0]   blend_r;
  logic [SEED_W-1:0] v_r;
  logic [SEED_W-1:0] res_r;

  // output register
  logic              out_valid_r;
  logic [SEED_W-1:0] out_data_r;

  // input unpacking
  logic              in_func;
  logic [LG+COORD_W-1:0] x_ext, y_ext;
  logic [LG-1:0]     x_in, y_in;
  logic [SEED_W-1:0] seed_in;
  logic              in_acc;

  // octave geometry
  logic [OCT_W-1:0]  octs_c;
  logic [BIAS_W-1:0] bias_c;
  logic [PLOG_W-1:0] plog;
  logic [PW-1:0]     pitch, pmask;
  logic [LG-1:0]     x1, y1, x2, y2;
  logic [PW-1:0]     dx, dy, pdx, pdy;
  logic [SH_W-1:0]   sh;
  logic              last_oct;

  // shared units
  logic [TOP_W-1:0]    mul_a;
  logic [WGT_HALF-1:0] mul_b;
  logic [P_W-1:0]      prod;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SEED_W-1:0]   ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [SEED_W-1:0]   quo_out;

  // input fields; coordinates keep their low LG bits
  assign in_func  = in_tuser[0];
  assign x_ext    = (LG + COORD_W)'(in_tdata[6:0]);
  assign y_ext    = (LG + COORD_W)'(in_tdata[13:7]);
  assign x_in     = x_ext[LG-1:0];
  assign y_in     = y_ext[LG-1:0];
  assign seed_in  = in_tdata[29:14];
  assign in_acc   = in_tvalid && in_tready;

  // effective octave count and bias
  always_comb begin
    octs_c = (octave_count_r == '0) ? OCT_W'(1) : octave_count_r;
    if (int'(octs_c) > OCT_CAP) begin
      octs_c = OCT_W'(OCT_CAP);
    end
    bias_c = (scaling_bias_r == '0) ? BIAS_W'(1) : scaling_bias_r;
  end

  // cell corners and blend fractions of the current octave
  assign plog     = PLOG_W'(LG) - PLOG_W'(oct_r);
  assign pitch    = PW'(1) << plog;
  assign pmask    = pitch - PW'(1);
  assign x1       = x_r & ~pmask[LG-1:0];
  assign y1       = y_r & ~pmask[LG-1:0];
  assign x2       = x1 + pitch[LG-1:0];
  assign y2       = y1 + pitch[LG-1:0];
  assign dx       = PW'(x_r & pmask[LG-1:0]);
  assign dy       = PW'(y_r & pmask[LG-1:0]);
  assign pdx      = pitch - dx;
  assign pdy      = pitch - dy;
  assign sh       = {plog, 1'b0};
  assign last_oct = (oct_r == octs_r - OCT_W'(1));

  // shared multiplier
  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // normalized result, saturating
  assign quo_out = (div_rsp.sat || (div_rsp.quo[QUO_W-1:SEED_W] != '0)) ?
                   OUT_MAX : div_rsp.quo[SEED_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_func == FUNC_QUERY)) begin
          state_nxt = ST_READ;
          step_nxt  = '0;
        end
      end
      ST_READ: begin
        if (step_r == RS_LAST) begin
          state_nxt = ST_MUL;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_MUL: begin
        if (step_r == MS_ACC_HI) begin
          state_nxt = last_oct ? ST_DIVF : ST_DIVW;
          step_nxt  = DS_START;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DIVW: begin
        step_nxt = DS_WAIT;
        if (div_rsp.done) begin
          state_nxt = ST_READ;
          step_nxt  = '0;
        end
      end
      ST_DIVF: begin
        step_nxt = DS_WAIT;
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
          step_nxt  = '0;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    ram_we        = in_tvalid && (state_r == ST_IDLE) && (in_func == FUNC_LOAD);
    ram_waddr     = {y_in, x_in};
    ram_raddr     = {y1, x1};
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = DIV_W'(acc_r);
    div_req.dsh   = DIV_W'(wsum_r) << (OUT_QBITS - QB_W'(1));
    div_req.qbits = OUT_QBITS;
    unique case (state_r)
      ST_READ: begin
        case (step_r[1:0])
          2'd1:    ram_raddr = {y1, x2};
          2'd2:    ram_raddr = {y2, x1};
          2'd3:    ram_raddr = {y2, x2};
          default: ram_raddr = {y1, x1};
        endcase
      end
      ST_MUL: begin
        case (step_r)
          MS_TOP_A: begin
            mul_a = TOP_W'(seed_r[0]);
            mul_b = WGT_HALF'(pdx);
          end
          MS_TOP_B: begin
            mul_a = TOP_W'(seed_r[1]);
            mul_b = WGT_HALF'(dx);
          end
          MS_BOT_A: begin
            mul_a = TOP_W'(seed_r[2]);
            mul_b = WGT_HALF'(pdx);
          end
          MS_BOT_B: begin
            mul_a = TOP_W'(seed_r[3]);
            mul_b = WGT_HALF'(dx);
          end
          MS_BLEND_A: begin
            mul_a = top_r;
            mul_b = WGT_HALF'(pdy);
          end
          MS_BLEND_B: begin
            mul_a = bot_r;
            mul_b = WGT_HALF'(dy);
          end
          MS_ACC_LO: begin
            mul_a = TOP_W'(v_r);
            mul_b = weight_r[WGT_HALF-1:0];
          end
          MS_ACC_HI: begin
            mul_a = TOP_W'(v_r);
            mul_b = weight_r[WGT_W-1:WGT_HALF];
          end
          default: begin
          end
        endcase
      end
      ST_DIVW: begin
        div_req.start = (step_r == DS_START);
        div_req.num   = DIV_W'({weight_r, 8'd0});
        div_req.dsh   = DIV_W'(bias_r) << (WGT_QBITS - QB_W'(1));
        div_req.qbits = WGT_QBITS;
      end
      ST_DIVF: div_req.start = (step_r == DS_START);
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration writes
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= OCT_RESET;
      scaling_bias_r <= BIAS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_OCTAVE_COUNT: octave_count_r <= cfg_pwdata[OCT_W-1:0];
        REG_SCALING_BIAS: scaling_bias_r <= cfg_pwdata[BIAS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_paddr[2])
      REG_OCTAVE_COUNT: cfg_prdata = 32'(octave_count_r);
      REG_SCALING_BIAS: cfg_prdata = 32'(scaling_bias_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // query datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FUNC_QUERY)) begin
          x_r      <= x_in;
          y_r      <= y_in;
          octs_r   <= octs_c;
          bias_r   <= bias_c;
          oct_r    <= '0;
          weight_r <= WGT_ONE;
          acc_r    <= '0;
          wsum_r   <= '0;
        end
      end
      ST_READ: begin
        if (step_r != '0) begin
          seed_r[step_r[1:0] - 2'd1] <= ram_rdata;
        end
      end
      ST_MUL: begin
        case (step_r)
          MS_TOP_A:   top_r   <= prod[TOP_W-1:0];
          MS_TOP_B:   top_r   <= top_r + prod[TOP_W-1:0];
          MS_BOT_A:   bot_r   <= prod[TOP_W-1:0];
          MS_BOT_B:   bot_r   <= bot_r + prod[TOP_W-1:0];
          MS_BLEND_A: blend_r <= prod[BL_W-1:0];
          MS_BLEND_B: blend_r <= blend_r + prod[BL_W-1:0];
          MS_SHIFT: begin
            v_r <= SEED_W'(blend_r >> sh);
          end
          MS_ACC_LO:  acc_r   <= acc_r + ACC_W'(prod);
          MS_ACC_HI: begin
            acc_r  <= acc_r + (ACC_W'(prod) << WGT_HALF);
            wsum_r <= wsum_r + WSUM_W'(weight_r);
          end
          default: begin
          end
        endcase
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          weight_r <= div_rsp.sat ? WGT_MAX : div_rsp.quo;
          oct_r    <= oct_r + OCT_W'(1);
        end
      end
      ST_DIVF: begin
        if (div_rsp.done) begin
          res_r <= quo_out;
        end
      end
      default: begin
      end
    endcase
  end

  // output payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // seed map
  ovn2d_ram #(
    .WIDTH (SEED_W),
    .DEPTH (SIDE * SIDE)
  ) u_seed_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (seed_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared divider for weight decay and final normalization
  ovn2d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

`ifndef SYNTHESIS
  // a query beat takes the block busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == FUNC_QUERY)) |=> !in_tready)
    else $error("input still ready after a query beat");

  // divider answers only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == ST_DIVW) || (state_r == ST_DIVF)))
    else $error("divider done outside a divide step");

  // octave index stays inside the clamped count while a query runs
  a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (oct_r < octs_r))
    else $error("octave index beyond octave count");

  // a result appears only from the hand-off step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

// ===== src/ovn2d_ram.sv =====
// ---------------------------------------------------------------------------
// ovn2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ovn2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ovn2d_div.sv =====
// ---------------------------------------------------------------------------
// ovn2d_div
// Restoring divider, one quotient bit per cycle. A first cycle checks whether
// the quotient overflows the requested number of bits and flags saturation.
// ---------------------------------------------------------------------------
module ovn2d_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ovn2d_pkg::div_req_t req,
  output ovn2d_pkg::div_rsp_t rsp
);

  import ovn2d_pkg::*;

  div_state_t       state_r, state_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [QB_W-1:0]  cnt_r, cnt_nxt;
  logic             sat_r, sat_nxt;
  logic             over;
  logic             ge;

  // quotient would need more than qbits bits
  assign over = {1'b0, rem_r} >= {dsh_r, 1'b0};
  // trial subtract of the aligned divisor
  assign ge   = rem_r >= dsh_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE:  if (req.start) state_nxt = DV_CHECK;
      DV_CHECK: state_nxt = over ? DV_DONE : DV_RUN;
      DV_RUN:   if (cnt_r == QB_W'(1)) state_nxt = DV_DONE;
      DV_DONE:  state_nxt = DV_IDLE;
      default:  state_nxt = DV_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    sat_nxt = sat_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          rem_nxt = req.num;
          dsh_nxt = req.dsh;
          cnt_nxt = req.qbits;
          quo_nxt = '0;
          sat_nxt = 1'b0;
        end
      end
      DV_CHECK: sat_nxt = over;
      DV_RUN: begin
        if (ge) begin
          rem_nxt = rem_r - dsh_r;
        end
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - QB_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
  end

  // outputs
  always_comb begin
    rsp.done = (state_r == DV_DONE);
    rsp.sat  = sat_r;
    rsp.quo  = quo_r;
  end

endmodule

// ===== sim/tb_octave_value_noise_2d_unit.sv =====
// ---------------------------------------------------------------------------
// tb_octave_value_noise_2d_unit
// Self-checking bench for the octave value noise unit. Seed loads and noise
// queries are queued by a stimulus process and sent by a bursty driver. Every
// accepted query is run through a bit-exact octave blend predictor that keeps
// its own seed map and register copies. Result beats are checked in order
// against the predicted noise values while the receiver stalls on its own
// pattern, including one long hold-off that backs the block up. Registers
// are only rewritten once the unit has drained.
// ---------------------------------------------------------------------------
module tb_octave_value_noise_2d_unit;
  import ovn2d_pkg::*;

  localparam int MAP_SIDE      = 128;
  localparam int SIDE_LOG      = 7;
  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 3000;
  localparam int LIMIT_CYCLES  = 2000000;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SEED_W-1:0]  seed;
  } noise_beat_t;

  // dut signals; the inputs start at known values from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // x_pos[6:0], y_pos[13:7], seed_value[29:14], zero
  logic [0:0]  in_tuser = '0;   // func[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // noise_value[15:0]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: seed map and register copies
  logic [SEED_W-1:0] seed_mem [0:MAP_SIDE*MAP_SIDE-1];
  logic [OCT_W-1:0]  oct_reg = OCT_RESET;
  logic [BIAS_W-1:0] bias_reg = BIAS_RESET;

  // stimulus bookkeeping: entries already loaded, as seen by the generator
  bit                seed_known [0:MAP_SIDE*MAP_SIDE-1];
  noise_beat_t       beat_q [$];
  logic [SEED_W-1:0] noise_q [$];
  int                pending_beats = 0;
  int                pushed_items = 0;
  int                mismatches = 0;
  int                result_idx = 0;

  // driver and receiver state
  noise_beat_t       nxt_beat;
  logic              beat_taken = 1'b0;
  int                burst_left = 0;
  int                gap_left = 0;
  bit                hold_go = 1'b0;
  int                hold_cnt = 0;
  int                mode_left = 0;
  logic [1:0]        rdy_mode = '0;
  logic [SEED_W-1:0] want_noise;

  octave_value_noise_2d_unit #(.SIDE(MAP_SIDE)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // ---- predictor ----

  function automatic int unsigned active_octaves();
    int unsigned octs;
    octs = (oct_reg == '0) ? 1 : oct_reg;
    if (octs > SIDE_LOG) octs = SIDE_LOG;
    return octs;
  endfunction

  function automatic logic [63:0] seed_at(input logic [63:0] col, input logic [63:0] row);
    return 64'(seed_mem[{row[COORD_W-1:0], col[COORD_W-1:0]}]);
  endfunction

  // weighted bilinear blend over all active octaves, normalized and saturated
  function automatic logic [SEED_W-1:0] octave_noise(input logic [COORD_W-1:0] xc,
                                                      input logic [COORD_W-1:0] yc);
    logic [63:0] pitch, x1, y1, x2, y2, dx, dy, top, bot, blend;
    logic [63:0] weight, wsum, acc, quo, bias;
    int unsigned octs, plog, lvl;
    octs = active_octaves();
    bias = (bias_reg == '0) ? 64'd1 : 64'(bias_reg);
    weight = 64'(WGT_ONE);
    wsum = '0;
    acc = '0;
    for (lvl = 0; lvl < octs; lvl++) begin
      plog = SIDE_LOG - lvl;
      pitch = 64'd1 << plog;
      x1 = 64'(xc) & ~(pitch - 64'd1);
      y1 = 64'(yc) & ~(pitch - 64'd1);
      x2 = (x1 + pitch) & 64'(MAP_SIDE - 1);
      y2 = (y1 + pitch) & 64'(MAP_SIDE - 1);
      dx = 64'(xc) - x1;
      dy = 64'(yc) - y1;
      top = (pitch - dx) * seed_at(x1, y1) + dx * seed_at(x2, y1);
      bot = (pitch - dx) * seed_at(x1, y2) + dx * seed_at(x2, y2);
      blend = ((pitch - dy) * top + dy * bot) >> (2 * plog);
      wsum += weight;
      acc += blend * weight;
      // next octave weight, saturated to the 40-bit format
      weight = (weight * 64'd256) / bias;
      if (weight > 64'(WGT_MAX)) weight = 64'(WGT_MAX);
    end
    quo = acc / wsum;
    return (quo > 64'(OUT_MAX)) ? OUT_MAX : quo[SEED_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  // ---- input driver: bursts of beats with random gaps ----
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || beat_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (beat_q.size() != 0) begin
        nxt_beat = beat_q.pop_front();
        in_tdata <= {2'b00, nxt_beat.seed, nxt_beat.y, nxt_beat.x};
        in_tuser <= nxt_beat.func;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---- result receiver: one long hold-off, otherwise a changing stall mode ----
  always @(negedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(64, 400);
        rdy_mode = 2'($urandom_range(0, 3));
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= (mode_left[3:2] != 2'b00);
      endcase
    end
  end

  // ---- beat monitor: predict on accepted input, check accepted results ----
  always @(posedge clk) begin
    beat_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      pending_beats--;
      if (in_tuser[0] == FUNC_LOAD) begin
        seed_mem[in_tdata[13:0]] = in_tdata[29:14];
      end else begin
        noise_q.push_back(octave_noise(in_tdata[6:0], in_tdata[13:7]));
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (noise_q.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d with no query waiting: %h",
                                result_idx, out_tdata));
      end else begin
        want_noise = noise_q.pop_front();
        if (out_tdata !== want_noise)
          flag_mismatch($sformatf("noise_value of result beat %0d: got %h want %h",
                                  result_idx, out_tdata, want_noise));
      end
      result_idx++;
    end
  end

  // ---- stimulus helpers ----

  function automatic logic [SEED_W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OUT_MAX;
      default: return SEED_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {COORD_W{1'b1}};
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [BIAS_W-1:0] pick_bias();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return BIAS_W'(1);
      2: return BIAS_W'(26);
      3: return BIAS_W'(8192);
      4: return {BIAS_W{1'b1}};
      default: return BIAS_W'($urandom_range(26, 8192));
    endcase
  endfunction

  task automatic queue_load(input logic [COORD_W-1:0] xc, input logic [COORD_W-1:0] yc,
                            input logic [SEED_W-1:0] val);
    seed_known[{yc, xc}] = 1'b1;
    beat_q.push_back('{func: FUNC_LOAD, x: xc, y: yc, seed: val});
    pending_beats++;
    pushed_items++;
  endtask

  // load any corner seed that the query would read before it was written
  task automatic queue_query(input logic [COORD_W-1:0] xc, input logic [COORD_W-1:0] yc);
    int unsigned lvl, pitch;
    logic [COORD_W-1:0] cx [2];
    logic [COORD_W-1:0] cy [2];
    for (lvl = 0; lvl < active_octaves(); lvl++) begin
      pitch = MAP_SIDE >> lvl;
      cx[0] = xc & COORD_W'(~(pitch - 1));
      cy[0] = yc & COORD_W'(~(pitch - 1));
      cx[1] = COORD_W'(cx[0] + pitch);
      cy[1] = COORD_W'(cy[0] + pitch);
      for (int i = 0; i < 4; i++)
        if (!seed_known[{cy[i/2], cx[i%2]}]) queue_load(cx[i%2], cy[i/2], pick_seed());
    end
    beat_q.push_back('{func: FUNC_QUERY, x: xc, y: yc, seed: SEED_W'($urandom)});
    pending_beats++;
    pushed_items++;
  endtask

  // wait for every queued beat and every expected result, then let it settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats != 0 || noise_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_OCTAVE_COUNT) oct_reg = val[OCT_W-1:0];
    else bias_reg = val[BIAS_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // unused upper bits carry random junk
  task automatic set_config(input logic [OCT_W-1:0] octs, input logic [BIAS_W-1:0] bias);
    logic [31:0] word;
    word = $urandom;
    word[OCT_W-1:0] = octs;
    write_reg(REG_OCTAVE_COUNT, word);
    word = $urandom;
    word[BIAS_W-1:0] = bias;
    write_reg(REG_SCALING_BIAS, word);
  endtask

  // ---- stimulus and end of run ----
  initial begin
    int base, phase_idx, phase_len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single octave: only the origin seed is read, full-scale then zero
    set_config(OCT_W'(1), BIAS_W'(512));
    queue_load('0, '0, OUT_MAX);
    queue_query('0, '0);
    queue_query(7'd127, 7'd127);
    queue_query(7'd64, 7'd33);
    queue_load('0, '0, '0);
    queue_query(7'd127, '0);
    wait_idle();

    // octave count zero and bias zero
    set_config('0, '0);
    queue_load('0, '0, 16'h8000);
    queue_query(7'd5, 7'd120);
    queue_query(7'd127, 7'd127);
    wait_idle();

    // all octaves with slow, fastest and growing weights, then three octaves
    set_config(OCT_W'(7), BIAS_W'(8192));
    queue_query(7'd127, 7'd127);
    queue_query('0, '0);
    queue_query(7'd1, 7'd126);
    wait_idle();
    set_config(OCT_W'(7), {BIAS_W{1'b1}});
    queue_query(7'd126, 7'd1);
    wait_idle();
    set_config(OCT_W'(7), BIAS_W'(1));
    queue_query(7'd1, 7'd1);
    queue_query(7'd127, 7'd64);
    wait_idle();
    set_config(OCT_W'(3), BIAS_W'(26));
    queue_query(7'd100, 7'd37);
    wait_idle();

    // random phases: mostly queries with their corners loaded, some stray loads
    base = pushed_items;
    phase_idx = 0;
    while (pushed_items - base < RANDOM_ITEMS) begin
      set_config(OCT_W'($urandom_range(0, 7)), pick_bias());
      phase_len = $urandom_range(30, 90);
      // the first phase backs the unit up behind a long receiver hold-off
      if (phase_idx == 0) begin
        hold_go = 1'b1;
        phase_len = 90;
      end
      for (int n = 0; n < phase_len && pushed_items - base < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 2) queue_load(pick_coord(), pick_coord(), pick_seed());
        else queue_query(pick_coord(), pick_coord());
      end
      wait_idle();
      phase_idx++;
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * 8);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
